// ----- hdl/erc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  // Car geometry.
  localparam int FLOORS  = 4;
  localparam int FLOOR_W = $clog2(FLOORS);

  // Tick counters and configuration port.
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [TICK_W-1:0] DOOR_TICKS_RST      = TICK_W'(30);
  localparam logic [TICK_W-1:0] STOP_HOLD_TICKS_RST = TICK_W'(1500);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD_TICKS = CFG_IDX_W'(1);

  // Travel direction and motor command codes.
  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } dir_t;

  // Controller modes.
  typedef enum logic [4:0] {
    MODE_RUNNING   = 5'b00001,
    MODE_DOOR      = 5'b00010,
    MODE_STOP_HELD = 5'b00100,
    MODE_STOP_HOLD = 5'b01000,
    MODE_STOP_WAIT = 5'b10000
  } mode_t;

  // What the direction chooser looks at.
  typedef struct packed {
    logic [FLOORS-1:0]  pending;
    logic [FLOOR_W-1:0] floor;
    dir_t               dir;
  } dir_req_t;

endpackage

`default_nettype wire

// ----- hdl/elevator_request_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Elevator request controller. Every panel sample transferred on the input
// channel yields exactly one result on the output channel. The block takes
// one sample per clock cycle while the output does not stall; a result
// passes two register stages (an input register, then the controller state
// and the result register, which are updated together). Stall on the output
// holds the pipeline, and a sample is still taken while a finished result
// waits, as long as the input register is free to move on. Write the tick
// registers only while no sample is in flight.

module elevator_request_controller
  import erc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TICK_W-1:0]    cfg_data,
  // Panel samples
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_floor_valid,
  input  wire logic [FLOOR_W-1:0]   in_floor_number,
  input  wire logic [FLOORS-1:0]    in_hall_up_pressed,
  input  wire logic [FLOORS-1:0]    in_hall_down_pressed,
  input  wire logic [FLOORS-1:0]    in_car_pressed,
  input  wire logic                 in_stop_pressed,
  input  wire logic                 in_obstructed,
  // Results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_motor_command,
  output logic [1:0]                out_travel_direction,
  output logic                      out_door_lamp,
  output logic                      out_stop_lamp,
  output logic [FLOORS-1:0]         out_up_lamps,
  output logic [FLOORS-1:0]         out_down_lamps,
  output logic [FLOORS-1:0]         out_car_lamps,
  output logic [FLOOR_W-1:0]        out_floor_indicator
);

  // Configuration registers
  logic [TICK_W-1:0] door_ticks_r;
  logic [TICK_W-1:0] stop_hold_ticks_r;

  // Input register
  logic               s1_valid_r;
  logic               s1_floor_valid_r;
  logic [FLOOR_W-1:0] s1_floor_number_r;
  logic [FLOORS-1:0]  s1_up_r;
  logic [FLOORS-1:0]  s1_down_r;
  logic [FLOORS-1:0]  s1_car_r;
  logic               s1_stop_r;
  logic               s1_obstr_r;

  // Controller state
  logic [FLOORS-1:0]  up_req_r, up_req_nxt;
  logic [FLOORS-1:0]  down_req_r, down_req_nxt;
  logic [FLOORS-1:0]  car_req_r, car_req_nxt;
  logic [FLOOR_W-1:0] last_floor_r, last_floor_nxt;
  dir_t               dir_r, dir_nxt;
  mode_t              mode_r, mode_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;

  // Result register
  logic               out_valid_r;
  dir_t               motor_nxt;

  // Work signals
  logic               out_ready;
  logic               s1_fire;
  logic               at_floor;
  logic [FLOORS-1:0]  up_lat;
  logic [FLOORS-1:0]  down_lat;
  logic [FLOORS-1:0]  car_lat;
  logic [FLOORS-1:0]  keep_mask;
  logic               any_lat;
  logic               serve_here;
  dir_req_t           dir_req;
  dir_t               dir_decided;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_ticks_r      <= DOOR_TICKS_RST;
      stop_hold_ticks_r <= STOP_HOLD_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DOOR_TICKS:      door_ticks_r      <= cfg_data;
        CFG_STOP_HOLD_TICKS: stop_hold_ticks_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: the result register frees up when it is empty or taken.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_floor_valid_r  <= in_floor_valid;
      s1_floor_number_r <= in_floor_number;
      s1_up_r           <= in_hall_up_pressed;
      s1_down_r         <= in_hall_down_pressed;
      s1_car_r          <= in_car_pressed;
      s1_stop_r         <= in_stop_pressed;
      s1_obstr_r        <= in_obstructed;
    end
  end

  // Requests with this sample's buttons added, and the floor seen now.
  assign at_floor  = s1_floor_valid_r &&
                     ({1'b0, s1_floor_number_r} < (FLOOR_W + 1)'(FLOORS));
  assign up_lat    = up_req_r | s1_up_r;
  assign down_lat  = down_req_r | s1_down_r;
  assign car_lat   = car_req_r | s1_car_r;
  assign any_lat   = |(up_lat | down_lat | car_lat);
  assign keep_mask = ~(FLOORS'(1) << s1_floor_number_r);

  // Direction chooser on the updated requests.
  assign dir_req.pending = up_lat | down_lat | car_lat;
  assign dir_req.floor   = s1_floor_number_r;
  assign dir_req.dir     = dir_r;

  erc_dir u_dir (
    .req     (dir_req),
    .dir_nxt (dir_decided)
  );

  // Stop here for a cab call, or a hall call in the new direction.
  assign serve_here = car_lat[s1_floor_number_r] ||
                      (up_lat[s1_floor_number_r] && (dir_decided == DIR_UP)) ||
                      (down_lat[s1_floor_number_r] && (dir_decided == DIR_DOWN));

  // Mode sequencing and request bookkeeping for one sample.
  always_comb begin
    up_req_nxt     = up_req_r;
    down_req_nxt   = down_req_r;
    car_req_nxt    = car_req_r;
    last_floor_nxt = last_floor_r;
    dir_nxt        = dir_r;
    mode_nxt       = mode_r;
    tick_nxt       = tick_r;
    motor_nxt      = DIR_STILL;

    case (mode_r)
      MODE_RUNNING: begin
        if (s1_stop_r) begin
          up_req_nxt   = '0;
          down_req_nxt = '0;
          car_req_nxt  = '0;
          mode_nxt     = MODE_STOP_HELD;
        end else begin
          up_req_nxt   = up_lat;
          down_req_nxt = down_lat;
          car_req_nxt  = car_lat;
          if (at_floor) begin
            last_floor_nxt = s1_floor_number_r;
            dir_nxt        = dir_decided;
            if (serve_here) begin
              up_req_nxt   = up_lat & keep_mask;
              down_req_nxt = down_lat & keep_mask;
              car_req_nxt  = car_lat & keep_mask;
              tick_nxt     = door_ticks_r;
              mode_nxt     = MODE_DOOR;
            end else begin
              motor_nxt = dir_decided;
            end
          end else begin
            motor_nxt = dir_r;
          end
        end
      end
      MODE_DOOR: begin
        if (s1_stop_r) begin
          up_req_nxt   = '0;
          down_req_nxt = '0;
          car_req_nxt  = '0;
          mode_nxt     = MODE_STOP_HELD;
        end else begin
          up_req_nxt   = up_lat;
          down_req_nxt = down_lat;
          car_req_nxt  = car_lat;
          if (s1_obstr_r) begin
            tick_nxt = door_ticks_r;
          end else if (tick_r <= TICK_W'(1)) begin
            if (at_floor) begin
              up_req_nxt   = up_lat & keep_mask;
              down_req_nxt = down_lat & keep_mask;
              car_req_nxt  = car_lat & keep_mask;
            end
            if (!(|(up_req_nxt | down_req_nxt | car_req_nxt))) begin
              dir_nxt = DIR_STILL;
            end
            tick_nxt = '0;
            mode_nxt = MODE_RUNNING;
          end else begin
            tick_nxt = tick_r - TICK_W'(1);
          end
        end
      end
      MODE_STOP_HELD: begin
        if (!s1_stop_r) begin
          tick_nxt = stop_hold_ticks_r;
          mode_nxt = MODE_STOP_HOLD;
        end
      end
      MODE_STOP_HOLD: begin
        if (s1_stop_r) begin
          up_req_nxt   = '0;
          down_req_nxt = '0;
          car_req_nxt  = '0;
          mode_nxt     = MODE_STOP_HELD;
        end else if (tick_r <= TICK_W'(1)) begin
          tick_nxt = '0;
          mode_nxt = MODE_STOP_WAIT;
        end else begin
          tick_nxt = tick_r - TICK_W'(1);
        end
      end
      MODE_STOP_WAIT: begin
        if (s1_stop_r) begin
          up_req_nxt   = '0;
          down_req_nxt = '0;
          car_req_nxt  = '0;
          mode_nxt     = MODE_STOP_HELD;
        end else begin
          up_req_nxt   = up_lat;
          down_req_nxt = down_lat;
          car_req_nxt  = car_lat;
          if (any_lat) begin
            if (at_floor) begin
              last_floor_nxt = s1_floor_number_r;
              dir_nxt        = dir_decided;
            end
            mode_nxt = MODE_RUNNING;
          end
        end
      end
      default: begin
        mode_nxt = MODE_RUNNING;
      end
    endcase
  end

  // Controller state advances once per sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_req_r     <= '0;
      down_req_r   <= '0;
      car_req_r    <= '0;
      last_floor_r <= '0;
      dir_r        <= DIR_STILL;
      mode_r       <= MODE_RUNNING;
      tick_r       <= '0;
    end else if (s1_fire) begin
      up_req_r     <= up_req_nxt;
      down_req_r   <= down_req_nxt;
      car_req_r    <= car_req_nxt;
      last_floor_r <= last_floor_nxt;
      dir_r        <= dir_nxt;
      mode_r       <= mode_nxt;
      tick_r       <= tick_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_motor_command    <= motor_nxt;
      out_travel_direction <= dir_nxt;
      out_door_lamp        <= (mode_nxt == MODE_DOOR) || (mode_nxt == MODE_STOP_HELD) ||
                              (mode_nxt == MODE_STOP_HOLD);
      out_stop_lamp        <= (mode_nxt == MODE_STOP_HELD);
      out_up_lamps         <= up_req_nxt;
      out_down_lamps       <= down_req_nxt;
      out_car_lamps        <= car_req_nxt;
      out_floor_indicator  <= last_floor_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The motor only runs with the door shut, and only in the travel direction.
  a_motor_matches_dir : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_motor_command != DIR_STILL)) |->
      ((out_motor_command == out_travel_direction) && !out_door_lamp))
    else $error("motor runs against travel direction or with door open");

  // While the stop button is held every request lamp is dark and the door lamp is lit.
  a_stop_clears_lamps : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_lamp) |->
      ((out_up_lamps == '0) && (out_down_lamps == '0) && (out_car_lamps == '0)
       && out_door_lamp))
    else $error("requests pending while stop is held");

  // The tick counter is zero outside the door, stop-hold and stop-held modes.
  a_tick_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r != '0) |->
      ((mode_r == MODE_DOOR) || (mode_r == MODE_STOP_HOLD) || (mode_r == MODE_STOP_HELD)))
    else $error("tick counter running in an untimed mode");

endmodule

`default_nettype wire

// ----- hdl/erc_dir.sv -----
`timescale 1ns / 1ps
`default_nettype none

module erc_dir
  import erc_pkg::*;
(
  input  dir_req_t req,
  output dir_t     dir_nxt
);

  logic [FLOOR_W-1:0] top;
  logic [FLOOR_W-1:0] bottom;

  // Highest pending floor; zero when nothing is pending.
  always_comb begin
    top = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (req.pending[i]) begin
        top = FLOOR_W'(i);
      end
    end
  end

  // Lowest pending floor; the top floor when nothing is pending.
  always_comb begin
    bottom = FLOOR_W'(FLOORS - 1);
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (req.pending[i]) begin
        bottom = FLOOR_W'(i);
      end
    end
  end

  // Keep going while requests lie ahead, otherwise turn around.
  always_comb begin
    dir_nxt = req.dir;
    case (req.dir)
      DIR_STILL: begin
        if (top > req.floor) begin
          dir_nxt = DIR_UP;
        end else if (bottom < req.floor) begin
          dir_nxt = DIR_DOWN;
        end
      end
      DIR_UP: begin
        if (top <= req.floor) begin
          dir_nxt = DIR_DOWN;
        end
      end
      DIR_DOWN: begin
        if (bottom >= req.floor) begin
          dir_nxt = DIR_UP;
        end
      end
      default: begin
        dir_nxt = req.dir;
      end
    endcase
  end

endmodule

`default_nettype wire
